### src/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg: shared types and constants of the reflectance sensor calibrator
// Field widths, register map, item codes and the queue entry format.
// ----------------------------------------------------------------------------
package rsc_pkg;

  // field widths
  localparam int SAMPLE_W = 12;
  localparam int CH_W     = 4;
  localparam int LEVEL_W  = 10;
  localparam int ALPHA_W  = 9;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // default channel count
  localparam int CHANNELS_DEF = 16;

  // register reset values
  localparam logic [SAMPLE_W-1:0] MID_RST   = 12'd2048;
  localparam logic [ALPHA_W-1:0]  ALPHA_RST = 9'd26;

  // store reset values
  localparam logic [SAMPLE_W-1:0] LOW_RST  = 12'd0;
  localparam logic [SAMPLE_W-1:0] HIGH_RST = 12'd4095;

  // arithmetic constants
  localparam logic [ALPHA_W-1:0] Q8_ONE    = 9'd256;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd1000;

  // numerator of the read: |sample - min| * 1000 fits 22 bits
  localparam int NUM_W     = 22;
  localparam int DIV_STEPS = NUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // register index (paddr[3:2])
  typedef enum logic [1:0] {
    REG_MID   = 2'd0,
    REG_ALPHA = 2'd1,
    REG_WHITE = 2'd2
  } reg_idx_t;

  // classified item operation
  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_NULL_READ = 2'd1,
    OP_CAL_HIGH  = 2'd2,
    OP_CAL_LOW   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

endpackage

### src/reflectance_sensor_calibrator.sv
// ----------------------------------------------------------------------------
// reflectance_sensor_calibrator: line sensor min/max calibration
// Tracks per-channel minimum and maximum levels and maps raw samples to a
// calibrated 0..1000 reflectance value.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; up to two
// beats queue ahead of the execution unit, and busy rises only when that
// queue is full. A calibration beat passes the load, calc and write states
// of the execution unit and returns nothing. A read beat runs a store
// fetch, a multiply, then a 22-step restoring divider, one quotient bit per
// cycle, and returns one result: done is high for exactly one cycle with
// channel_out and level. The receiver cannot stall results, so it must
// take every done cycle. Reads of missing channels or equal stores return 0.
// ----------------------------------------------------------------------------
module reflectance_sensor_calibrator #(
  parameter int CHANNELS = rsc_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // command beat
  input  logic                         start,
  output logic                         busy,
  input  logic                         cmd,
  input  logic [rsc_pkg::CH_W-1:0]     channel,
  input  logic [rsc_pkg::SAMPLE_W-1:0] sample,
  // result beat
  output logic                         done,
  output logic [rsc_pkg::CH_W-1:0]     channel_out,
  output logic [rsc_pkg::LEVEL_W-1:0]  level,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [rsc_pkg::DATA_W-1:0]   pwdata,
  output logic [rsc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import rsc_pkg::*;

  logic [SAMPLE_W-1:0] mid_level;
  logic [ALPHA_W-1:0]  smoothing_q8;
  logic                white_line;
  logic                wr_en;

  logic  q_full;
  logic  q_empty;
  logic  push;
  logic  pop;
  item_t push_item;
  item_t head;

  // register file
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_level    <= MID_RST;
      smoothing_q8 <= ALPHA_RST;
      white_line   <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_MID:   mid_level    <= pwdata[SAMPLE_W-1:0];
        REG_ALPHA: smoothing_q8 <= pwdata[ALPHA_W-1:0];
        REG_WHITE: white_line   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MID:   prdata = {{(DATA_W - SAMPLE_W){1'b0}}, mid_level};
      REG_ALPHA: prdata = {{(DATA_W - ALPHA_W){1'b0}}, smoothing_q8};
      REG_WHITE: prdata = {{(DATA_W - 1){1'b0}}, white_line};
      default:   prdata = '0;
    endcase
  end

  // intake
  rsc_front #(.CHANNELS(CHANNELS)) u_front (
    .start     (start),
    .cmd       (cmd),
    .channel   (channel),
    .sample    (sample),
    .mid_level (mid_level),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .item      (push_item)
  );

  // decoupling queue
  rsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // execution
  rsc_back #(.CHANNELS(CHANNELS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .smoothing_q8 (smoothing_q8),
    .white_line   (white_line),
    .done         (done),
    .channel_out  (channel_out),
    .level        (level)
  );

endmodule

### src/rsc_front.sv
// ----------------------------------------------------------------------------
// rsc_front: command intake
// Accepts command beats, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module rsc_front #(
  parameter int CHANNELS = rsc_pkg::CHANNELS_DEF
) (
  input  logic                         start,
  input  logic                         cmd,
  input  logic [rsc_pkg::CH_W-1:0]     channel,
  input  logic [rsc_pkg::SAMPLE_W-1:0] sample,
  input  logic [rsc_pkg::SAMPLE_W-1:0] mid_level,
  input  logic                         q_full,
  output logic                         busy,
  output logic                         push,
  output rsc_pkg::item_t               item
);
  import rsc_pkg::*;

  logic accept;
  logic ch_ok;

  // stall only when the queue has no room
  assign busy   = q_full;
  assign accept = start && !q_full;
  assign ch_ok  = ({1'b0, channel} < (CH_W + 1)'(CHANNELS));

  // classify; a calibration beat on a missing channel is dropped
  always_comb begin
    item.channel = channel;
    item.sample  = sample;
    item.op      = OP_READ;
    push         = accept;
    if (!cmd) begin
      item.op = ch_ok ? OP_READ : OP_NULL_READ;
    end else if (!ch_ok) begin
      push = 1'b0;
    end else if (sample > mid_level) begin
      item.op = OP_CAL_HIGH;
    end else begin
      item.op = OP_CAL_LOW;
    end
  end

endmodule

### src/rsc_queue.sv
// ----------------------------------------------------------------------------
// rsc_queue: short item queue
// Small FIFO that decouples command intake from the execution unit.
// ----------------------------------------------------------------------------
module rsc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rsc_pkg::item_t push_item,
  input  logic           pop,
  output rsc_pkg::item_t head,
  output logic           empty,
  output logic           full
);
  import rsc_pkg::*;

  item_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule

### src/rsc_back.sv
// ----------------------------------------------------------------------------
// rsc_back: execution unit
// Holds the min/max stores, runs calibration updates and calibrated reads
// with a 22-step restoring divider.
// ----------------------------------------------------------------------------
module rsc_back #(
  parameter int CHANNELS = rsc_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  rsc_pkg::item_t               head,
  output logic                         pop,
  input  logic [rsc_pkg::ALPHA_W-1:0]  smoothing_q8,
  input  logic                         white_line,
  output logic                         done,
  output logic [rsc_pkg::CH_W-1:0]     channel_out,
  output logic [rsc_pkg::LEVEL_W-1:0]  level
);
  import rsc_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PROD_W = ALPHA_W + SAMPLE_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_CALC  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_DIV   = 5'b10000
  } state_t;

  state_t state;

  logic [SAMPLE_W-1:0] low_mem  [CHANNELS];
  logic [SAMPLE_W-1:0] high_mem [CHANNELS];

  item_t               cur;
  logic [IDX_W-1:0]    idx;
  logic [SAMPLE_W-1:0] lo_q;
  logic [SAMPLE_W-1:0] hi_q;
  logic [PROD_W-1:0]   prod_old;
  logic [PROD_W-1:0]   prod_new;
  logic [NUM_W-1:0]    quo;
  logic [SAMPLE_W-1:0] rem;
  logic [SAMPLE_W-1:0] den_mag;
  logic                neg;
  logic [STEP_W-1:0]   step_cnt;

  // combinational helpers
  logic [ALPHA_W-1:0]  w;
  logic [ALPHA_W-1:0]  inv_w;
  logic [SAMPLE_W-1:0] old_val;
  logic [PROD_W-1:0]   ema_sum;
  logic [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]   den;
  logic [SAMPLE_W-1:0] diff_mag;
  logic [SAMPLE_W-1:0] den_abs;
  logic [SAMPLE_W:0]   rem_sh;
  logic                q_bit;
  logic [SAMPLE_W-1:0] rem_next;
  logic [NUM_W-1:0]    quo_next;
  logic [LEVEL_W-1:0]  clamped;
  logic [LEVEL_W-1:0]  final_level;

  assign idx = cur.channel[IDX_W-1:0];
  assign pop = (state == ST_IDLE) && !q_empty;

  // averaging weight, saturated at one
  assign w       = (smoothing_q8 > Q8_ONE) ? Q8_ONE : smoothing_q8;
  assign inv_w   = Q8_ONE - w;
  assign old_val = (cur.op == OP_CAL_HIGH) ? hi_q : lo_q;
  assign ema_sum = prod_old + prod_new;

  // signed differences and magnitudes
  assign diff     = {1'b0, cur.sample} - {1'b0, lo_q};
  assign den      = {1'b0, hi_q} - {1'b0, lo_q};
  assign diff_mag = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
  assign den_abs  = den[SAMPLE_W] ? SAMPLE_W'(-den) : den[SAMPLE_W-1:0];

  // one restoring divide step
  assign rem_sh   = {rem, quo[NUM_W-1]};
  assign q_bit    = (rem_sh >= {1'b0, den_mag});
  assign rem_next = q_bit ? SAMPLE_W'(rem_sh - {1'b0, den_mag}) : rem_sh[SAMPLE_W-1:0];
  assign quo_next = {quo[NUM_W-2:0], q_bit};

  // clamp to 0..1000, optional inversion
  assign clamped     = neg ? '0
                     : (quo_next > NUM_W'(LEVEL_MAX)) ? LEVEL_MAX : quo_next[LEVEL_W-1:0];
  assign final_level = white_line ? (LEVEL_MAX - clamped) : clamped;

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        low_mem[i]  <= LOW_RST;
        high_mem[i] <= HIGH_RST;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            cur   <= head;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (cur.op == OP_NULL_READ) begin
            done        <= 1'b1;
            channel_out <= cur.channel;
            level       <= '0;
            state       <= ST_IDLE;
          end else begin
            lo_q  <= low_mem[idx];
            hi_q  <= high_mem[idx];
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (cur.op == OP_CAL_HIGH || cur.op == OP_CAL_LOW) begin
            prod_old <= {{SAMPLE_W{1'b0}}, inv_w} * {{ALPHA_W{1'b0}}, old_val};
            prod_new <= {{SAMPLE_W{1'b0}}, w} * {{ALPHA_W{1'b0}}, cur.sample};
            state    <= ST_WRITE;
          end else if (den == '0) begin
            // equal stores read as zero, not inverted
            done        <= 1'b1;
            channel_out <= cur.channel;
            level       <= '0;
            state       <= ST_IDLE;
          end else begin
            quo      <= {{(NUM_W - SAMPLE_W){1'b0}}, diff_mag}
                        * {{(NUM_W - LEVEL_W){1'b0}}, LEVEL_MAX};
            rem      <= '0;
            den_mag  <= den_abs;
            neg      <= diff[SAMPLE_W] ^ den[SAMPLE_W];
            step_cnt <= '0;
            state    <= ST_DIV;
          end
        end
        ST_WRITE: begin
          if (cur.op == OP_CAL_HIGH) high_mem[idx] <= ema_sum[SAMPLE_W+7:8];
          else                       low_mem[idx]  <= ema_sum[SAMPLE_W+7:8];
          state <= ST_IDLE;
        end
        ST_DIV: begin
          rem      <= rem_next;
          quo      <= quo_next;
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == STEP_W'(DIV_STEPS - 1)) begin
            done        <= 1'b1;
            channel_out <= cur.channel;
            level       <= final_level;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### dv/tb_reflectance_sensor_calibrator.sv
// ----------------------------------------------------------------------------
// tb_reflectance_sensor_calibrator: self-checking bench for the calibrator
// A directed table walks reset levels, full-scale reads, white line
// inversion, equal and crossed stores and weights at and above one.
// Calibration sweeps followed by mixed calibrate/read traffic then run
// under several register settings. Every read result is checked against
// a typed level or an in-bench predictor of the per-channel min/max stores.
// ----------------------------------------------------------------------------
module tb_reflectance_sensor_calibrator;
  timeunit 1ns;
  timeprecision 1ps;

  import rsc_pkg::*;

  // command codes
  localparam logic CMD_READ = 1'b0;
  localparam logic CMD_CAL  = 1'b1;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASES        = 8;
  localparam int PHASE_BEATS   = 235;
  localparam int SWEEP_BEATS   = 24;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic                op;
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] smp;
    reg_idx_t            rsel;
    logic [SAMPLE_W-1:0] wval;
    logic                chk;
    logic [LEVEL_W-1:0]  lvl;
  } stim_row_t;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [LEVEL_W-1:0] lvl;
  } level_beat_t;

  logic                clk;
  logic                rst     = 1'b1;
  logic                start   = 1'b0;
  logic                busy;
  logic                cmd     = CMD_READ;
  logic [CH_W-1:0]     channel = '0;
  logic [SAMPLE_W-1:0] sample  = '0;
  logic                done;
  logic [CH_W-1:0]     channel_out;
  logic [LEVEL_W-1:0]  level;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // predictor copy of stores and registers
  logic [SAMPLE_W-1:0] low_store  [CHANNELS_DEF];
  logic [SAMPLE_W-1:0] high_store [CHANNELS_DEF];
  logic [SAMPLE_W-1:0] mid_q;
  logic [ALPHA_W-1:0]  alpha_q;
  logic                white_q;

  level_beat_t levels_due[$];
  int          err_count   = 0;
  int          cycle_count = 0;

  // directed table: expected level typed only where obvious
  stim_row_t dir_rows [29] = '{
    '{ROW_BEAT, CMD_READ, 4'd0,  12'd0,    REG_MID,   12'd0,    1'b1, 10'd0},
    '{ROW_BEAT, CMD_READ, 4'd15, 12'd4095, REG_MID,   12'd0,    1'b1, 10'd1000},
    '{ROW_BEAT, CMD_READ, 4'd3,  12'd2048, REG_MID,   12'd0,    1'b0, 10'd0},
    '{ROW_REG,  CMD_READ, 4'd0,  12'd0,    REG_WHITE, 12'd1,    1'b0, 10'd0},
    '{ROW_BEAT, CMD_READ, 4'd1,  12'd4095, REG_MID,   12'd0,    1'b1, 10'd0},
    '{ROW_BEAT, CMD_READ, 4'd2,  12'd0,    REG_MID,   12'd0,    1'b1, 10'd1000},
    '{ROW_REG,  CMD_READ, 4'd0,  12'd0,    REG_WHITE, 12'd0,    1'b0, 10'd0},
    '{ROW_REG,  CMD_READ, 4'd0,  12'd0,    REG_ALPHA, 12'd256,  1'b0, 10'd0},
    '{ROW_REG,  CMD_READ, 4'd0,  12'd0,    REG_MID,   12'd4095, 1'b0, 10'd0},
    '{ROW_BEAT, CMD_CAL,  4'd5,  12'd3000, REG_MID,   12'd0,    1'b0, 10'd0},
    '{ROW_BEAT, CMD_CAL,  4'd6,  12'd4000, REG_MID,   12'd0,    1'b0, 10'd0},
    '{ROW_REG,  CMD_READ, 4'd0,  12'd0,    REG_MID,   12'd0,    1'b0, 10'd0},
    '{ROW_BEAT, CMD_CAL,  4'd5,  12'd3000, REG_MID,   12'd0,    1'b0, 10'd0},
    '{ROW_BEAT, CMD_CAL,  4'd6,  12'd500,  REG_MID,   12'd0,    1'b0, 10'd0},
    '{ROW_BEAT, CMD_READ, 4'd5,  12'd3000, REG_MID,   12'd0,    1'b1, 10'd0},
    '{ROW_BEAT, CMD_READ, 4'd5,  12'd0,    REG_MID,   12'd0,    1'b1, 10'd0},
    '{ROW_BEAT, CMD_READ, 4'd6,  12'd1000, REG_MID,   12'd0,    1'b0, 10'd0},
    '{ROW_BEAT, CMD_READ, 4'd6,  12'd4095, REG_MID,   12'd0,    1'b1, 10'd0},
    '{ROW_BEAT, CMD_READ, 4'd6,  12'd0,    REG_MID,   12'd0,    1'b1, 10'd1000},
    '{ROW_REG,  CMD_READ, 4'd0,  12'd0,    REG_ALPHA, 12'd511,  1'b0, 10'd0},
    '{ROW_BEAT, CMD_CAL,  4'd7,  12'd1234, REG_MID,   12'd0,    1'b0, 10'd0},
    '{ROW_BEAT, CMD_READ, 4'd7,  12'd1234, REG_MID,   12'd0,    1'b1, 10'd1000},
    '{ROW_REG,  CMD_READ, 4'd0,  12'd0,    REG_WHITE, 12'd1,    1'b0, 10'd0},
    '{ROW_BEAT, CMD_READ, 4'd5,  12'd3000, REG_MID,   12'd0,    1'b1, 10'd0},
    '{ROW_BEAT, CMD_READ, 4'd7,  12'd1234, REG_MID,   12'd0,    1'b1, 10'd0},
    '{ROW_REG,  CMD_READ, 4'd0,  12'd0,    REG_ALPHA, 12'd0,    1'b0, 10'd0},
    '{ROW_BEAT, CMD_CAL,  4'd8,  12'd4000, REG_MID,   12'd0,    1'b0, 10'd0},
    '{ROW_BEAT, CMD_CAL,  4'd8,  12'd0,    REG_MID,   12'd0,    1'b0, 10'd0},
    '{ROW_BEAT, CMD_READ, 4'd8,  12'd2000, REG_MID,   12'd0,    1'b0, 10'd0}
  };

  reflectance_sensor_calibrator #(
    .CHANNELS(CHANNELS_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .channel(channel),
    .sample(sample),
    .done(done),
    .channel_out(channel_out),
    .level(level),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // exponential average in Q1.8, weight saturated at one
  function automatic logic [SAMPLE_W-1:0] blend_q8(input logic [SAMPLE_W-1:0] prev,
                                                   input logic [SAMPLE_W-1:0] smp,
                                                   input logic [ALPHA_W-1:0]  a);
    int unsigned w;
    int unsigned acc;
    w   = (a > Q8_ONE) ? int'(Q8_ONE) : int'(a);
    acc = ((256 - w) * prev + w * smp) >> 8;
    return SAMPLE_W'(acc);
  endfunction

  // map sample onto 0..1000 between the stores, clamp, optional inversion
  function automatic logic [LEVEL_W-1:0] scale_level(input logic [SAMPLE_W-1:0] smp,
                                                     input logic [SAMPLE_W-1:0] lo,
                                                     input logic [SAMPLE_W-1:0] hi);
    longint num;
    longint den;
    longint q;
    if (hi == lo) return '0;
    num = (longint'(smp) - longint'(lo)) * 1000;
    den = longint'(hi) - longint'(lo);
    q   = num / den;
    if (q < 0) q = 0;
    if (q > 1000) q = 1000;
    if (white_q) q = 1000 - q;
    return LEVEL_W'(q);
  endfunction

  // update stores or queue the expected level for one accepted beat
  task automatic track_beat(input logic c, input logic [CH_W-1:0] ch,
                            input logic [SAMPLE_W-1:0] smp, input logic chk,
                            input logic [LEVEL_W-1:0] lvl);
    level_beat_t b;
    b.ch  = ch;
    b.lvl = '0;
    if (c == CMD_CAL) begin
      if (int'(ch) < CHANNELS_DEF) begin
        if (smp > mid_q) high_store[ch] = blend_q8(high_store[ch], smp, alpha_q);
        else low_store[ch] = blend_q8(low_store[ch], smp, alpha_q);
      end
    end else begin
      if (chk) b.lvl = lvl;
      else if (int'(ch) < CHANNELS_DEF) b.lvl = scale_level(smp, low_store[ch], high_store[ch]);
      levels_due.push_back(b);
    end
  endtask

  // drive one command beat, with an optional random gap in front
  task automatic push_beat(input logic c, input logic [CH_W-1:0] ch,
                           input logic [SAMPLE_W-1:0] smp, input logic chk,
                           input logic [LEVEL_W-1:0] lvl, input bit steady);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 8)
      gap = ($urandom_range(9) == 0) ? $urandom_range(40, 2) : 1;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    cmd     <= c;
    channel <= ch;
    sample  <= smp;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    track_beat(c, ch, smp, chk, lvl);
  endtask

  // hold off commands until every pending level is back
  task automatic wait_drained(input bit settle);
    start <= 1'b0;
    @(posedge clk);
    while (levels_due.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write: setup then access, only with the block idle
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    wait_drained(1'b1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MID:   mid_q   = val[SAMPLE_W-1:0];
      REG_ALPHA: alpha_q = val[ALPHA_W-1:0];
      REG_WHITE: white_q = val[0];
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin : level_check
    level_beat_t want;
    if (!rst && done === 1'b1) begin
      if (levels_due.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result beat: expected none, actual ch %0d level %0d",
                 $time, channel_out, level);
      end else begin
        want = levels_due.pop_front();
        if (channel_out !== want.ch) begin
          err_count++;
          $display("%0t: channel_out mismatch: expected %0d actual %0d",
                   $time, want.ch, channel_out);
        end
        if (level !== want.lvl) begin
          err_count++;
          $display("%0t: level mismatch on ch %0d: expected %0d actual %0d",
                   $time, want.ch, want.lvl, level);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("reflectance_sensor_calibrator test failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [SAMPLE_W-1:0] m;
    logic [ALPHA_W-1:0]  a;
    logic                w;
    logic                c;
    logic [CH_W-1:0]     ch;
    logic [CH_W-1:0]     focus;
    logic [SAMPLE_W-1:0] smp;
    int                  pause_at;
    bit                  steady;

    mid_q   = MID_RST;
    alpha_q = ALPHA_RST;
    white_q = 1'b0;
    for (int i = 0; i < CHANNELS_DEF; i++) begin
      low_store[i]  = LOW_RST;
      high_store[i] = HIGH_RST;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG)
        write_reg(dir_rows[i].rsel, DATA_W'(dir_rows[i].wval));
      else
        push_beat(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].smp,
                  dir_rows[i].chk, dir_rows[i].lvl, 1'b0);
    end

    // random phases: a calibration sweep, then mixed traffic
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin m = MID_RST;     a = ALPHA_RST; w = 1'b0; end
        1: begin m = '0;          a = Q8_ONE;    w = 1'b1; end
        2: begin m = '1;          a = '1;        w = 1'b0; end
        3: begin m = SAMPLE_W'($urandom); a = '0; w = 1'($urandom); end
        default: begin
          m = SAMPLE_W'($urandom);
          a = ALPHA_W'($urandom_range(511));
          w = 1'($urandom);
        end
      endcase
      write_reg(REG_MID, DATA_W'(m));
      write_reg(REG_ALPHA, DATA_W'(a));
      write_reg(REG_WHITE, DATA_W'(w));

      steady   = (p == 2);
      focus    = CH_W'($urandom_range(15));
      pause_at = $urandom_range(PHASE_BEATS - 1, 40);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (k == pause_at) wait_drained(1'b0);
        c  = (k < SWEEP_BEATS || $urandom_range(99) < 40) ? CMD_CAL : CMD_READ;
        ch = ($urandom_range(3) == 0) ? focus : CH_W'($urandom_range(15));
        // dark and bright bands dominate, like a sensor over a line
        case ($urandom_range(9))
          0:       smp = '0;
          1:       smp = '1;
          2, 3, 4: smp = SAMPLE_W'($urandom_range(800));
          5, 6, 7: smp = SAMPLE_W'($urandom_range(4095, 3300));
          default: smp = SAMPLE_W'($urandom_range(4095));
        endcase
        push_beat(c, ch, smp, 1'b0, '0, steady);
      end
    end

    wait_drained(1'b1);
    if (err_count == 0) begin
      $display("reflectance_sensor_calibrator test passed");
    end else begin
      $display("reflectance_sensor_calibrator test failed");
    end
    $finish;
  end

endmodule

### files.f
src/rsc_pkg.sv
src/rsc_front.sv
src/rsc_queue.sv
src/rsc_back.sv
src/reflectance_sensor_calibrator.sv
dv/tb_reflectance_sensor_calibrator.sv
